// File: hw/rtl/nopm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nopm_pkg
// Shared types and constants for the non-overlapping pattern matcher.
// ----------------------------------------------------------------------------
package nopm_pkg;

    // pattern and text geometry
    localparam int MAX_PAT    = 16;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int ES_W       = $clog2(MAX_PAT + 1);
    localparam int POS_W      = 16;
    localparam int CNT_W      = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    // saturation limits
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ES_W-1:0]  ES_MAX  = ES_W'(MAX_PAT);

    // window of recent bytes, entry 0 the newest
    typedef logic [MAX_PAT-1:0][BYTE_W-1:0] t_win;

    // item held between the window stage and the match stage
    typedef struct packed {
        logic vld;
        logic last;
        t_win win;
    } t_item;

    // pattern aligned to the window, entry j compared with window entry j
    typedef struct packed {
        logic                 en;
        logic [LEN_W-1:0]     len;
        logic [MAX_PAT-1:0]   mask;
        t_win                 bytes;
    } t_pat;

endpackage
`default_nettype wire

// File: hw/rtl/nopm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nopm_cfg
// Configuration registers and the pattern realigned to window order.
// ----------------------------------------------------------------------------
module nopm_cfg
    import nopm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_pat                       o_pat
);

    logic [CFG_DATA_W-1:0]   r_pat_lo;
    logic [CFG_DATA_W-1:0]   r_pat_hi;
    logic [LEN_W-1:0]        r_len;
    logic [2*CFG_DATA_W-1:0] pat_cat;
    logic [LEN_W-1:0]        sel;
    t_pat                    r_pat;
    t_pat                    n_pat;

    // register writes; unused index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAT_LO:  r_pat_lo <= i_cfg_wdata;
                REG_PAT_HI:  r_pat_hi <= i_cfg_wdata;
                REG_PAT_LEN: r_len    <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_cat = {r_pat_hi, r_pat_lo};

    // window entry j meets pattern byte len-1-j
    always_comb begin
        n_pat.en  = (r_len != '0) && (r_len <= LEN_W'(MAX_PAT));
        n_pat.len = r_len;
        sel       = '0;
        for (int k = 0; k < MAX_PAT; k++) begin
            sel            = r_len - LEN_W'(1) - LEN_W'(k);
            n_pat.mask[k]  = (LEN_W'(k) < r_len);
            n_pat.bytes[k] = pat_cat[BYTE_W*sel[$clog2(MAX_PAT)-1:0] +: BYTE_W];
        end
    end

    // aligned copy, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
        end else begin
            r_pat <= n_pat;
        end
    end

    assign o_pat = r_pat;

endmodule
`default_nettype wire

// File: hw/rtl/nopm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nopm_window
// Input register: shifts each byte into the history and captures the window.
// ----------------------------------------------------------------------------
module nopm_window
    import nopm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_text_byte,
    input  wire logic              i_is_last,
    input  wire logic              i_adv,
    output logic                   o_ready,
    output t_item                  o_item
);

    t_win  r_hist;
    t_win  win_new;
    logic  r_vld;
    logic  r_last;
    t_win  r_win;
    logic  accept;

    assign o_ready = !r_vld || i_adv;
    assign accept  = i_valid && o_ready;

    // newest byte in entry 0
    assign win_new = {r_hist[MAX_PAT-2:0], i_text_byte};

    // history clears after the last byte of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (accept) begin
            r_hist <= i_is_last ? '0 : win_new;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_is_last;
            r_win  <= win_new;
        end
    end

    // field order: vld, last, win
    assign o_item = {r_vld, r_last, r_win};

endmodule
`default_nettype wire

// File: hw/rtl/nopm_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nopm_match
// Window compare, per-string counters and the result register.
// ----------------------------------------------------------------------------
module nopm_match
    import nopm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_item            i_item,
    input  t_pat             i_pat,
    output logic             o_adv,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [CNT_W-1:0] o_match_count,
    output logic             o_found,
    output logic [POS_W-1:0] o_first_position
);

    logic [POS_W-1:0]   r_bidx,  n_bidx;
    logic [ES_W-1:0]    r_es,    n_es;
    logic [CNT_W-1:0]   r_occ,   n_occ;
    logic [POS_W-1:0]   r_first, n_first;
    logic               r_seen,  n_seen;
    logic               r_o_vld;
    logic [CNT_W-1:0]   r_o_cnt;
    logic               r_o_found;
    logic [POS_W-1:0]   r_o_pos;
    logic [MAX_PAT-1:0] byte_ok;
    logic [ES_W-1:0]    es_inc;
    logic [POS_W:0]     pos_calc;
    logic               hit;
    logic               out_free;

    // per-entry compare, unused entries pass
    always_comb begin
        for (int k = 0; k < MAX_PAT; k++) begin
            byte_ok[k] = !i_pat.mask[k] || (i_item.win[k] == i_pat.bytes[k]);
        end
    end

    // a last byte waits for a free result register
    assign out_free = !r_o_vld || i_ready;
    assign o_adv    = i_item.vld && (!i_item.last || out_free);

    assign es_inc   = (r_es < ES_MAX) ? r_es + ES_W'(1) : r_es;
    assign hit      = i_pat.en && ({1'b0, es_inc} >= (ES_W+1)'(i_pat.len)) && (&byte_ok);
    assign pos_calc = {1'b0, r_bidx} + (POS_W+1)'(2) - (POS_W+1)'(i_pat.len);

    // next per-string state
    always_comb begin
        n_es    = hit ? '0 : es_inc;
        n_occ   = (hit && r_occ != CNT_MAX) ? r_occ + CNT_W'(1) : r_occ;
        n_first = r_first;
        n_seen  = r_seen;
        if (hit && !r_seen) begin
            n_first = (r_bidx == POS_MAX) ? POS_MAX : pos_calc[POS_W-1:0];
            n_seen  = 1'b1;
        end
        n_bidx  = (r_bidx != POS_MAX) ? r_bidx + POS_W'(1) : r_bidx;
    end

    // string state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx  <= '0;
            r_es    <= '0;
            r_occ   <= '0;
            r_first <= '0;
            r_seen  <= 1'b0;
        end else if (o_adv) begin
            if (i_item.last) begin
                r_bidx  <= '0;
                r_es    <= '0;
                r_occ   <= '0;
                r_first <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_bidx  <= n_bidx;
                r_es    <= n_es;
                r_occ   <= n_occ;
                r_first <= n_first;
                r_seen  <= n_seen;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_adv && i_item.last) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_item.last) begin
            r_o_cnt   <= n_occ;
            r_o_found <= n_seen;
            r_o_pos   <= n_seen ? n_first : '0;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_match_count    = r_o_cnt;
    assign o_found          = r_o_found;
    assign o_first_position = r_o_pos;

endmodule
`default_nettype wire

// File: hw/rtl/nonoverlap_pattern_matcher_unit.sv
`default_nettype none
// A result is registered once its last byte has passed the window register.
// Throughput: one text byte per cycle; the window compare over 16 bytes and
// the counter update fit between the window register and the result register.
// A last byte holds the input only while an earlier result is still waiting.
// Reset: synchronous, active low; pattern registers clear, pattern length
// returns to 1, and all per-string state and pending results are dropped.
// ----------------------------------------------------------------------------
// nonoverlap_pattern_matcher_unit
// Counts non-overlapping pattern matches in a byte stream, reports per string.
// ----------------------------------------------------------------------------
module nonoverlap_pattern_matcher_unit
    import nopm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [BYTE_W-1:0]     i_text_byte,
    input  wire logic                  i_is_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CNT_W-1:0]           o_match_count,
    output logic                       o_found,
    output logic [POS_W-1:0]           o_first_position
);

    t_pat  pat;
    t_item item;
    logic  adv;

    nopm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pat       (pat)
    );

    nopm_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .i_adv       (adv),
        .o_ready     (o_ready),
        .o_item      (item)
    );

    nopm_match u_match (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (item),
        .i_pat            (pat),
        .o_adv            (adv),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_match_count    (o_match_count),
        .o_found          (o_found),
        .o_first_position (o_first_position)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the non-overlapping pattern matcher. Text strings
// are streamed in byte by byte with random gaps on both sides. A behavioural
// scan of the same bytes predicts each per-string summary (count, found and
// first position), which is checked field by field as it is transferred out.
// ----------------------------------------------------------------------------
module tb;
    import nopm_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [BYTE_W-1:0] text_q_t [$];

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             found;
        logic [POS_W-1:0] pos;
    } match_summary_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_text_byte;
    logic                  i_is_last;
    logic                  o_valid;
    logic                  i_ready;
    logic [CNT_W-1:0]      o_match_count;
    logic                  o_found;
    logic [POS_W-1:0]      o_first_position;

    nonoverlap_pattern_matcher_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_text_byte      (i_text_byte),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_match_count    (o_match_count),
        .o_found          (o_found),
        .o_first_position (o_first_position)
    );

    // pattern configuration as the block should hold it
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [LEN_W-1:0]      pat_len;

    // per-string scan state
    logic [BYTE_W-1:0] recent [MAX_PAT];
    int                bytes_before;
    int                since_free;
    int                hits;
    int                first_hit;
    bit                hit_seen;

    match_summary_t pending_summaries [$];

    int errors          = 0;
    int items_sent      = 0;
    int strings_checked = 0;
    int strings_found   = 0;
    int idle_cycles     = 0;
    int src_max_gap     = 7;
    int sink_max_gap    = 7;
    bit hold_req        = 1'b0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------
    function automatic void clear_text_state();
        foreach (recent[i]) recent[i] = '0;
        bytes_before = 0;
        since_free   = 0;
        hits         = 0;
        first_hit    = 0;
        hit_seen     = 1'b0;
    endfunction

    // one accepted text byte; queues a summary when it closes the string
    function automatic void scan_text_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [2*CFG_DATA_W-1:0] pattern;
        int                      len;
        bit                      hit;
        match_summary_t          s;
        pattern = {pat_hi, pat_lo};
        len     = int'(pat_len);
        for (int i = MAX_PAT - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        if (since_free < MAX_PAT) since_free++;
        // the match must lie after the previous one and inside the string
        hit = (len >= 1) && (len <= MAX_PAT) && (since_free >= len);
        for (int k = 0; k < MAX_PAT; k++) begin
            if (hit && k < len && recent[len - 1 - k] != pattern[BYTE_W*k +: BYTE_W])
                hit = 1'b0;
        end
        if (hit) begin
            if (hits < int'(CNT_MAX)) hits++;
            if (!hit_seen) begin
                first_hit = (bytes_before >= int'(POS_MAX)) ? int'(POS_MAX)
                                                             : bytes_before + 2 - len;
                hit_seen  = 1'b1;
            end
            since_free = 0;
        end
        if (bytes_before < int'(POS_MAX)) bytes_before++;
        if (last) begin
            s.count = CNT_W'(hits);
            s.found = hit_seen;
            s.pos   = hit_seen ? POS_W'(first_hit) : '0;
            pending_summaries.insert(pending_summaries.size(), s);
            clear_text_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // register write, only issued with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_PAT_LO:  pat_lo  = data;
            REG_PAT_HI:  pat_hi  = data;
            REG_PAT_LEN: pat_len = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [CFG_DATA_W-1:0] len);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_PAT_LEN, len);
    endtask

    // offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        i_is_last   <= last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        scan_text_byte(b, last);
    endtask

    task automatic send_text(input text_q_t text);
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    // wait until every summary is back and the pipeline has emptied
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, sink_max_gap);
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : summary_check
        match_summary_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t: unexpected result, count %0d found %0d position %0d",
                         $time, o_match_count, o_found, o_first_position);
                errors++;
            end else begin
                want = pending_summaries.pop_front();
                check_field("match_count", want.count, o_match_count);
                check_field("found", want.found, o_found);
                check_field("first_position", want.pos, o_first_position);
                strings_checked++;
                if (want.found) strings_found++;
            end
        end
    end

    // give up if nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset pattern is one zero byte; a write to the spare index changes nothing
    task automatic test_reset_pattern();
        send_byte(8'h00, 1'b1);
        drain_pipeline();
        write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_nonoverlap_rules();
        // "aa" in "aaaa" counts twice, not three times
        drain_pipeline();
        set_pattern(64'h6161, 64'h0, 64'd2);
        repeat (3) send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);
        // full-length pattern of extreme bytes
        drain_pipeline();
        set_pattern({CFG_DATA_W{1'b1}}, '0, 64'd16);
        repeat (8) send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // zero length, upper data bits ignored
        drain_pipeline();
        write_reg(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
        send_byte(8'hFF, 1'b1);
        // length beyond the window
        drain_pipeline();
        write_reg(REG_PAT_LEN, 64'h1F);
        send_byte(8'hFF, 1'b1);
    endtask

    // pattern changed half way through a string; window and counters stay
    task automatic test_midstring_reconfig();
        drain_pipeline();
        set_pattern(64'h4241, 64'h0, 64'd2);
        send_byte(8'h41, 1'b0);
        drain_pipeline();
        write_reg(REG_PAT_LO, 64'h4341);
        send_byte(8'h43, 1'b1);
    endtask

    // sink holds off while short strings keep coming, so the input backs up
    task automatic test_output_backpressure();
        drain_pipeline();
        set_pattern(64'h5A5A, 64'h0, 64'd2);
        src_max_gap = 0;
        hold_req    = 1'b1;
        repeat (60) begin
            send_byte(8'h5A, 1'b0);
            send_byte($urandom_range(0, 1) ? 8'h5A : 8'hA5, 1'b1);
        end
        src_max_gap = 7;
    endtask

    task automatic test_random_text();
        text_q_t                 text;
        logic [BYTE_W-1:0]       alpha [3];
        logic [2*CFG_DATA_W-1:0] pat;
        logic [CFG_DATA_W-1:0]   len_word;
        int                      len;
        int                      target;
        int                      cut;
        int                      r;
        int                      start_items;
        int                      phase;
        start_items = items_sent;
        phase       = 0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            drain_pipeline();
            foreach (alpha[a]) alpha[a] = BYTE_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom, $urandom, $urandom};
            else
                for (int k = 0; k < MAX_PAT; k++)
                    pat[BYTE_W*k +: BYTE_W] = alpha[$urandom_range(0, 2)];
            // short patterns mostly, now and then disabled or oversized
            r = $urandom_range(0, 19);
            if (r < 12)      len = $urandom_range(1, 4);
            else if (r < 17) len = $urandom_range(5, MAX_PAT);
            else if (r < 18) len = 0;
            else             len = $urandom_range(MAX_PAT + 1, 31);
            len_word = {$urandom, $urandom};
            len_word[LEN_W-1:0] = LEN_W'(len);
            set_pattern(pat[CFG_DATA_W-1:0], pat[2*CFG_DATA_W-1:CFG_DATA_W], len_word);
            // every fourth phase runs without gaps on either side
            src_max_gap  = (phase % 4 == 3) ? 0 : 7;
            sink_max_gap = src_max_gap;
            repeat ($urandom_range(6, 12)) begin
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(1, 12);
                text.delete();
                while (text.size() < target) begin
                    r = $urandom_range(0, 9);
                    if (r < 4 && len >= 1 && len <= MAX_PAT) begin
                        for (int k = 0; k < len; k++)
                            text.insert(text.size(), pat[BYTE_W*k +: BYTE_W]);
                    end else if (r == 4 && len >= 2 && len <= MAX_PAT) begin
                        // broken copy: a prefix only
                        cut = $urandom_range(1, len - 1);
                        for (int k = 0; k < cut; k++)
                            text.insert(text.size(), pat[BYTE_W*k +: BYTE_W]);
                    end else if (r == 9) begin
                        text.insert(text.size(), BYTE_W'($urandom));
                    end else begin
                        text.insert(text.size(), alpha[$urandom_range(0, 2)]);
                    end
                end
                send_text(text);
            end
            phase++;
        end
        src_max_gap  = 7;
        sink_max_gap = 7;
    endtask

    initial begin : main_seq
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_text_byte = '0;
        i_is_last   = 1'b0;
        pat_lo      = '0;
        pat_hi      = '0;
        pat_len     = LEN_RESET;
        clear_text_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pattern();
        test_nonoverlap_rules();
        test_midstring_reconfig();
        test_output_backpressure();
        test_random_text();
        drain_pipeline();

        $display("covered %0d text bytes in %0d strings, %0d of them with a match",
                 items_sent, strings_checked, strings_found);
        $display("lengths 0 to 31, mid-string pattern change, output hold-off, random text");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
